[src/fls_pkg.sv]
// Shared sizes, codes and types for the frame LIFO stack.
package fls_pkg;

  // Store sizes
  localparam int WORD_DEPTH    = 256;
  localparam int MAX_FRAMES    = 32;
  localparam int MAX_FRAME_LEN = 16;

  // Derived widths
  localparam int WORD_W  = 32;
  localparam int WADDR_W = $clog2(WORD_DEPTH);
  localparam int WPTR_W  = $clog2(WORD_DEPTH + 1);
  localparam int SLOT_W  = WPTR_W + 1;
  localparam int FIDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int LEN_W   = $clog2(MAX_FRAME_LEN + 1);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Word store access request
  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               re;
    logic [WADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

[src/fls_word_store.sv]
// Word store of the frame stack: one write port, one registered read port.
module fls_word_store (
  input  logic                         clk_i,
  input  fls_pkg::ram_req_t            req_i,
  output logic [fls_pkg::WORD_W-1:0]   rdata_o
);

  logic [fls_pkg::WORD_W-1:0] mem [fls_pkg::WORD_DEPTH];
  logic [fls_pkg::WORD_W-1:0] rdata_q;

  // Write the pushed word, register the drained word
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/frame_lifo_stack.sv]
// Top level of the frame LIFO stack: sequencer, frame bookkeeping and result register.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  command  | start_i, busy_o  | opcode_i, push_value_i, frame_end_i
//  result   | strobe_o         | word_out_o, last_word_o, status_o
//
// A push word and a frame end that commits give no result; a rejected frame end
// or a pop of an empty stack gives its result in the cycle after the command.
// A pop of a frame holds busy_o while its words drain: the single read port
// of the word store drains one word a cycle, each result in the cycle after its read.
// Reset clears the frame count, the pointers and the strobe; no clearing
// pass runs. Results are shown for one cycle each; the receiver cannot stall.
module frame_lifo_stack (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               opcode_i,
  input  logic signed [fls_pkg::WORD_W-1:0]  push_value_i,
  input  logic                               frame_end_i,
  output logic                               strobe_o,
  output logic signed [fls_pkg::WORD_W-1:0]  word_out_o,
  output logic                               last_word_o,
  output logic [1:0]                         status_o
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state_q, state_d;
  logic [fls_pkg::FCNT_W-1:0]  fc_q, fc_d;
  logic [fls_pkg::WPTR_W-1:0]  wp_q, wp_d;
  logic [fls_pkg::LEN_W-1:0]   pend_q, pend_d;
  logic                        rej_q, rej_d;
  logic [fls_pkg::WADDR_W-1:0] rd_q, rd_d;
  logic [fls_pkg::LEN_W-1:0]   cnt_q, cnt_d;

  logic       out_valid_q, out_valid_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_zero_q, out_zero_d;

  logic [fls_pkg::WADDR_W-1:0] fstart [fls_pkg::MAX_FRAMES];
  logic                        fs_we;
  logic [fls_pkg::FIDX_W-1:0]  fs_idx;
  logic [fls_pkg::FIDX_W-1:0]  top_idx;
  logic [fls_pkg::WADDR_W-1:0] base;

  logic [fls_pkg::SLOT_W-1:0]  slot;
  logic                        word_fits;
  logic [fls_pkg::LEN_W-1:0]   pend_n;
  logic                        rej_n;

  fls_pkg::ram_req_t           ram_req;
  logic [fls_pkg::WORD_W-1:0]  ram_rdata;

  // Locate the slot of the next push word and the top frame's start
  assign slot      = fls_pkg::SLOT_W'(wp_q) + fls_pkg::SLOT_W'(pend_q);
  assign word_fits = !rej_q && (32'(pend_q) < fls_pkg::MAX_FRAME_LEN)
                     && (32'(slot) < fls_pkg::WORD_DEPTH);
  assign top_idx   = fls_pkg::FIDX_W'(fc_q - fls_pkg::FCNT_W'(1));
  assign base      = fstart[top_idx];

  // Sequence push, commit, pop and drain
  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    wp_d         = wp_q;
    pend_d       = pend_q;
    rej_d        = rej_q;
    rd_d         = rd_q;
    cnt_d        = cnt_q;
    out_valid_d  = 1'b0;
    out_last_d   = 1'b0;
    out_status_d = fls_pkg::ST_DATA;
    out_zero_d   = 1'b1;
    fs_we        = 1'b0;
    fs_idx       = fc_q[fls_pkg::FIDX_W-1:0];
    ram_req      = '0;
    pend_n       = word_fits ? pend_q + fls_pkg::LEN_W'(1) : pend_q;
    rej_n        = rej_q | !word_fits;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == fls_pkg::OP_PUSH) begin
            ram_req.we    = word_fits;
            ram_req.waddr = slot[fls_pkg::WADDR_W-1:0];
            ram_req.wdata = push_value_i;
            if (frame_end_i) begin
              pend_d = '0;
              rej_d  = 1'b0;
              if (rej_n || (32'(fc_q) >= fls_pkg::MAX_FRAMES) || (pend_n == '0)) begin
                out_valid_d  = 1'b1;
                out_last_d   = 1'b1;
                out_status_d = fls_pkg::ST_OVERFLOW;
              end else begin
                fs_we = 1'b1;
                fc_d  = fc_q + fls_pkg::FCNT_W'(1);
                wp_d  = wp_q + fls_pkg::WPTR_W'(pend_n);
              end
            end else begin
              pend_d = pend_n;
              rej_d  = rej_n;
            end
          end else begin
            // Drop the partial frame, then pop
            pend_d = '0;
            rej_d  = 1'b0;
            if (fc_q == '0) begin
              out_valid_d  = 1'b1;
              out_last_d   = 1'b1;
              out_status_d = fls_pkg::ST_EMPTY;
            end else begin
              fc_d    = fc_q - fls_pkg::FCNT_W'(1);
              wp_d    = fls_pkg::WPTR_W'(base);
              rd_d    = base;
              cnt_d   = fls_pkg::LEN_W'(wp_q - fls_pkg::WPTR_W'(base));
              state_d = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        // Read one word a cycle, oldest first
        ram_req.re  = 1'b1;
        ram_req.raddr = rd_q;
        out_valid_d = 1'b1;
        out_zero_d  = 1'b0;
        out_last_d  = (cnt_q == fls_pkg::LEN_W'(1));
        rd_d        = rd_q + fls_pkg::WADDR_W'(1);
        cnt_d       = cnt_q - fls_pkg::LEN_W'(1);
        if (cnt_q == fls_pkg::LEN_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      wp_q        <= '0;
      pend_q      <= '0;
      rej_q       <= 1'b0;
      rd_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      wp_q        <= wp_d;
      pend_q      <= pend_d;
      rej_q       <= rej_d;
      rd_q        <= rd_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Register result payload
  always_ff @(posedge clk_i) begin
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
    out_zero_q   <= out_zero_d;
  end

  // Record frame starts on commit
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fstart[fs_idx] <= wp_q[fls_pkg::WADDR_W-1:0];
    end
  end

  fls_word_store u_store (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = (state_q == S_DRAIN);
  assign strobe_o    = out_valid_q;
  assign word_out_o  = out_zero_q ? '0 : ram_rdata;
  assign last_word_o = out_last_q;
  assign status_o    = out_status_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for frame_lifo_stack: directed table, random frames, stack predictor.
module tb_top;
  import fls_pkg::*;

  // One result word as seen on the result ports
  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     last;
    logic [1:0]               status;
  } stack_word_t;

  // One directed row: nwords push words per frame (or one pop), repeated nrep times
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] value;
    logic              fend;
    int                nwords;
    int                nrep;
    bit                typed;
    logic [WORD_W-1:0] t_word;
    logic [1:0]        t_status;
  } stim_row_t;

  localparam int NUM_ROWS    = 24;
  localparam int TOTAL_WORDS = 425;
  localparam int PAUSE_AT    = 405;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_TAIL  = 20;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // pop right after reset: empty
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
    // single-word frame at the positive extreme, popped back
    '{OP_PUSH, 32'h7FFF_FFFF, 1'b1,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b1, 32'h7FFF_FFFF, ST_DATA},
    // three-word frame with extremes, then a partial frame dropped by the pop
    '{OP_PUSH, 32'h8000_0000, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_PUSH, 32'hFFFF_FFFF, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_PUSH, 32'h0000_0000, 1'b1,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_PUSH, 32'h1234_5678, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
    // frame one word too long: rejected
    '{OP_PUSH, 32'hA5A5_A5A5, 1'b1, 17,  1, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    // frame of the maximum length
    '{OP_PUSH, 32'h5A5A_5A5A, 1'b1, 16,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    // fill the word store exactly, then overflow it
    '{OP_PUSH, 32'h0100_0000, 1'b1, 16, 16, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_PUSH, 32'h7FFF_FFFF, 1'b1,  1,  1, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    '{OP_PUSH, 32'h8000_0001, 1'b1,  3,  1, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    '{OP_POP,  32'h0000_0000, 1'b0,  1, 16, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
    // fill the frame count, then overflow it
    '{OP_PUSH, 32'h0000_0000, 1'b1,  1, 32, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_PUSH, 32'hDEAD_BEEF, 1'b1,  1,  1, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    // pop while building, then drain
    '{OP_PUSH, 32'hCAFE_F00D, 1'b0,  2,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1, 31, 1'b0, 32'h0000_0000, ST_DATA},
    '{OP_POP,  32'h0000_0000, 1'b0,  1,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
    // push fields on a pop are ignored
    '{OP_POP,  32'hFFFF_FFFF, 1'b1,  1,  1, 1'b1, 32'h0000_0000, ST_EMPTY}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic                     opcode_i = OP_PUSH;
  logic signed [WORD_W-1:0] push_value_i = '0;
  logic                     frame_end_i = 1'b0;
  logic                     strobe_o;
  logic signed [WORD_W-1:0] word_out_o;
  logic                     last_word_o;
  logic [1:0]               status_o;

  // Stack predictor state
  logic signed [WORD_W-1:0] mem_words [WORD_DEPTH];
  logic [WADDR_W-1:0]       frame_base [MAX_FRAMES];
  logic [FCNT_W-1:0]        frame_cnt = '0;
  logic [WPTR_W-1:0]        wr_ptr = '0;
  logic [LEN_W-1:0]         build_len = '0;
  logic                     build_bad = 1'b0;

  stack_word_t expected_words [$];
  int          fail_cnt = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          burst_mode = 1'b0;

  frame_lifo_stack dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .frame_end_i  (frame_end_i),
    .strobe_o     (strobe_o),
    .word_out_o   (word_out_o),
    .last_word_o  (last_word_o),
    .status_o     (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Advance the predicted stack by one accepted word; append its results
  function automatic void predict_stack(input logic op, input logic [WORD_W-1:0] value,
                                        input logic fend, ref stack_word_t res_q[$]);
    logic [SLOT_W-1:0] slot;
    logic [WPTR_W-1:0] base;
    int                len;
    if (op == OP_PUSH) begin
      slot = SLOT_W'(wr_ptr) + SLOT_W'(build_len);
      if (!build_bad) begin
        if (build_len >= MAX_FRAME_LEN || slot >= WORD_DEPTH) begin
          build_bad = 1'b1;
        end else begin
          mem_words[slot[WADDR_W-1:0]] = value;
          build_len = build_len + 1'b1;
        end
      end
      if (!fend) return;
      if (build_bad || frame_cnt >= MAX_FRAMES || build_len == 0) begin
        res_q.push_back('{'0, 1'b1, ST_OVERFLOW});
      end else begin
        frame_base[frame_cnt[FIDX_W-1:0]] = wr_ptr[WADDR_W-1:0];
        frame_cnt = frame_cnt + 1'b1;
        wr_ptr = wr_ptr + WPTR_W'(build_len);
      end
      build_len = '0;
      build_bad = 1'b0;
      return;
    end
    // Pop: drop any partial frame first
    build_len = '0;
    build_bad = 1'b0;
    if (frame_cnt == 0) begin
      res_q.push_back('{'0, 1'b1, ST_EMPTY});
      return;
    end
    frame_cnt = frame_cnt - 1'b1;
    base = WPTR_W'(frame_base[frame_cnt[FIDX_W-1:0]]);
    len = int'(wr_ptr - base);
    if (len > MAX_FRAME_LEN) len = MAX_FRAME_LEN;
    for (int i = 0; i < len; i++) begin
      res_q.push_back('{mem_words[WADDR_W'(base + WPTR_W'(i))], (i == len - 1), ST_DATA});
    end
    wr_ptr = base;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one command word, hold it until taken, then record what it should give
  task automatic send_word(input logic op, input logic [WORD_W-1:0] value, input logic fend,
                           input bit typed, input stack_word_t typed_res);
    int          gap;
    stack_word_t scratch [$];
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    opcode_i     <= op;
    push_value_i <= value;
    frame_end_i  <= fend;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (typed) begin
      predict_stack(op, value, fend, scratch);
      expected_words.push_back(typed_res);
    end else begin
      predict_stack(op, value, fend, expected_words);
    end
    words_sent++;
  endtask

  // Hold off the sender until every expected result has come
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  // Pick a frame length: mostly short, some up to the limit, a few too long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, MAX_FRAME_LEN);
    return $urandom_range(MAX_FRAME_LEN + 1, MAX_FRAME_LEN + 4);
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    stack_word_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result: word_out %0d last_word %0b status %0d",
               word_out_o, last_word_o, status_o);
        fail_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (word_out_o !== want.word) begin
          $error("word_out: expected %0d, got %0d", want.word, word_out_o);
          fail_cnt++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, last_word_o);
          fail_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || strobe_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("frame_lifo_stack: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    stack_word_t typed_res;
    int          len;
    int          r;
    bit          push_heavy;
    bit          drained_once;
    drained_once = 1'b0;

    // Hold reset, then release on a clock edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int k = 0; k < NUM_ROWS; k++) begin
      row = DIRECTED_ROWS[k];
      typed_res = '{row.t_word, 1'b1, row.t_status};
      for (int rep = 0; rep < row.nrep; rep++) begin
        for (int j = 0; j < row.nwords; j++) begin
          send_word(row.op, row.value + WORD_W'(rep * row.nwords + j),
                    row.fend && (j == row.nwords - 1),
                    row.typed && (rep == row.nrep - 1) && (j == row.nwords - 1),
                    typed_res);
        end
      end
    end

    // Random frames and pops, alternating push-heavy and pop-heavy stretches
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent % 40 < 2) burst_mode = ($urandom_range(0, 3) == 0);
      push_heavy = ((words_sent / 64) % 2) == 0;
      if (!drained_once && words_sent >= PAUSE_AT) begin
        drain_results();
        drained_once = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < (push_heavy ? 75 : 40)) begin
        len = pick_len();
        for (int j = 0; j < len; j++) begin
          send_word(OP_PUSH, $urandom, (j == len - 1), 1'b0, '0);
        end
      end else if (r < 92) begin
        send_word(OP_POP, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        // Partial frame: left open for a pop to drop or a later frame to extend
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          send_word(OP_PUSH, $urandom, 1'b0, 1'b0, '0);
        end
      end
    end

    // Drop start, wait for all results, then let the block settle
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (fail_cnt == 0 && expected_words.size() == 0) begin
      $display("frame_lifo_stack: match");
    end else begin
      $display("frame_lifo_stack: mismatch");
    end
    $finish;
  end

endmodule
